// File: rtl/gsr_pkg.sv
// Shared types and constants for the gyro spike rejector.
// Holds field widths, register reset values, register indexes and the
// structs that pass between the front queue, the back stage and the top level.
`timescale 1ns / 1ps

package gsr_pkg;

	// Fixed field widths.
	localparam int CHANNEL_W   = 4;
	localparam int THRESH_W    = 16;
	localparam int LIMIT_W     = 4;
	localparam int COUNT_W     = 4;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	// Register reset values: 0.048 in units of 2^-10 rounds to 49.
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd49;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd6;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPIKE_THRESHOLD = 4'd0,
		REG_PERSIST_LIMIT   = 4'd1
	} cfg_reg_t;

	// Control part of one queued item, produced by the front classifier.
	typedef struct packed {
		logic                 in_range;
		logic [CHANNEL_W-1:0] channel;
	} gsr_ctl_t;

	// Live configuration handed to the back stage.
	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic [LIMIT_W-1:0]  limit;
	} gsr_cfg_t;

endpackage

// File: rtl/gsr_front.sv
// Front part of the gyro spike rejector: accepts samples, classifies the
// channel index and holds items in a two-entry queue for the back stage.
// Depends on gsr_pkg.
`timescale 1ns / 1ps

module gsr_front #(
	parameter int CHANNELS     = 9,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [gsr_pkg::CHANNEL_W-1:0]    in_channel,
	input  logic [SAMPLE_WIDTH-1:0]          in_sample,
	output logic                             head_valid,
	output gsr_pkg::gsr_ctl_t                head_ctl,
	output logic [SAMPLE_WIDTH-1:0]          head_sample,
	input  logic                             head_pop
);

	gsr_pkg::gsr_ctl_t           ctl_q [2];
	logic [SAMPLE_WIDTH-1:0]     smp_q [2];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  count_q;
	gsr_pkg::gsr_ctl_t           ctl_in;
	logic                        push;
	logic                        pop;

	// Classify the incoming item: only channels below CHANNELS touch state.
	always_comb begin
		ctl_in.channel  = in_channel;
		ctl_in.in_range = (32'(in_channel) < CHANNELS);
	end

	assign in_ready    = (count_q != 2'd2);
	assign push        = in_valid && in_ready;
	assign head_valid  = (count_q != 2'd0);
	assign pop         = head_pop && head_valid;
	assign head_ctl    = ctl_q[rd_ptr_q];
	assign head_sample = smp_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue payload storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q] <= ctl_in;
			smp_q[wr_ptr_q] <= in_sample;
		end
	end

endmodule

// File: rtl/gsr_back.sv
// Back part of the gyro spike rejector: per-channel held sample and
// rejection count, the step test, and the output register.
// Depends on gsr_pkg.
`timescale 1ns / 1ps

module gsr_back #(
	parameter int CHANNELS     = 9,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gsr_pkg::gsr_cfg_t                cfg,
	input  logic                             head_valid,
	input  gsr_pkg::gsr_ctl_t                head_ctl,
	input  logic [SAMPLE_WIDTH-1:0]          head_sample,
	output logic                             head_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gsr_pkg::CHANNEL_W-1:0]    out_channel,
	output logic [SAMPLE_WIDTH-1:0]          out_filtered,
	output logic                             out_rejected
);

	// Only channels that the index field can reach need storage.
	localparam int MAX_CH = 1 << gsr_pkg::CHANNEL_W;
	localparam int DEPTH  = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAG_W  = SAMPLE_WIDTH + 1;
	localparam int CMP_W  = (MAG_W > gsr_pkg::THRESH_W) ? MAG_W : gsr_pkg::THRESH_W;

	logic [SAMPLE_WIDTH-1:0]         last_good_q [DEPTH];
	logic [gsr_pkg::COUNT_W-1:0]     reject_count_q [DEPTH];
	logic                            out_valid_q;
	logic [gsr_pkg::CHANNEL_W-1:0]   out_channel_q;
	logic [SAMPLE_WIDTH-1:0]         out_filtered_q;
	logic                            out_rejected_q;

	logic                            take;
	logic [IDX_W-1:0]                idx;
	logic [SAMPLE_WIDTH-1:0]         held;
	logic [gsr_pkg::COUNT_W-1:0]     count_cur;
	logic [MAG_W-1:0]                diff;
	logic [MAG_W-1:0]                mag;
	logic                            big_step;
	logic [gsr_pkg::COUNT_W-1:0]     count_inc;
	logic                            reject;

	// An item moves on when the output register is empty or being drained.
	assign take     = head_valid && (!out_valid_q || out_ready);
	assign head_pop = take;

	// Step test against the held sample of this channel.
	always_comb begin
		idx       = IDX_W'(head_ctl.channel);
		held      = last_good_q[idx];
		count_cur = reject_count_q[idx];
		diff      = {head_sample[SAMPLE_WIDTH-1], head_sample} - {held[SAMPLE_WIDTH-1], held};
		mag       = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
		big_step  = CMP_W'(mag) > CMP_W'(cfg.threshold);
		count_inc = count_cur + gsr_pkg::COUNT_W'(1);
		reject    = head_ctl.in_range && big_step && (count_inc < cfg.limit);
	end

	// Per-channel state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				last_good_q[i]    <= '0;
				reject_count_q[i] <= '0;
			end
		end else if (take && head_ctl.in_range) begin
			if (reject) begin
				reject_count_q[idx] <= count_inc;
			end else begin
				last_good_q[idx]    <= head_sample;
				reject_count_q[idx] <= '0;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_channel_q  <= head_ctl.channel;
			out_filtered_q <= reject ? held : head_sample;
			out_rejected_q <= reject;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_channel  = out_channel_q;
	assign out_filtered = out_filtered_q;
	assign out_rejected = out_rejected_q;

endmodule

// File: rtl/gyro_spike_rejector.sv
// Path: a sample accepted into the front queue passes the step test and is
// registered in the back-stage output register before it is offered.
// Throughput: one sample per cycle unless the result side stalls, set by the
// per-channel state read, step test and update in the back stage; a two-entry
// queue and the output register let input and output stall independently.
// Reset: asynchronous, clears held samples and counts to zero, threshold 49, limit 6.
`timescale 1ns / 1ps

module gyro_spike_rejector #(
	parameter int CHANNELS     = 9,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gsr_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Sample stream in.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: channel (4), sample (SAMPLE_WIDTH), zero pad.
	input  logic [((gsr_pkg::CHANNEL_W+SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// Result stream out.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: channel_out (4), filtered (SAMPLE_WIDTH), zero pad.
	output logic [((gsr_pkg::CHANNEL_W+SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
	// Fields from bit 0: rejected (1).
	output logic [0:0]                          m_tuser
);

	localparam int DATA_W = ((gsr_pkg::CHANNEL_W + SAMPLE_WIDTH + 7) / 8) * 8;

	logic [gsr_pkg::THRESH_W-1:0]   threshold_q;
	logic [gsr_pkg::LIMIT_W-1:0]    limit_q;
	gsr_pkg::gsr_cfg_t              cfg;
	logic                           head_valid;
	gsr_pkg::gsr_ctl_t              head_ctl;
	logic [SAMPLE_WIDTH-1:0]        head_sample;
	logic                           head_pop;
	logic [gsr_pkg::CHANNEL_W-1:0]  out_channel;
	logic [SAMPLE_WIDTH-1:0]        out_filtered;
	logic                           out_rejected;

	// Configuration registers; writes outside the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= gsr_pkg::THRESH_RESET;
			limit_q     <= gsr_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gsr_pkg::REG_SPIKE_THRESHOLD: begin
					threshold_q <= cfg_data;
				end
				gsr_pkg::REG_PERSIST_LIMIT: begin
					limit_q <= cfg_data[gsr_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.threshold = threshold_q;
		cfg.limit     = limit_q;
	end

	// Front: accept, classify, queue.
	gsr_front #(
		.CHANNELS     (CHANNELS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_channel  (s_tdata[gsr_pkg::CHANNEL_W-1:0]),
		.in_sample   (s_tdata[gsr_pkg::CHANNEL_W +: SAMPLE_WIDTH]),
		.head_valid  (head_valid),
		.head_ctl    (head_ctl),
		.head_sample (head_sample),
		.head_pop    (head_pop)
	);

	// Back: per-channel state and output register.
	gsr_back #(
		.CHANNELS     (CHANNELS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head_valid   (head_valid),
		.head_ctl     (head_ctl),
		.head_sample  (head_sample),
		.head_pop     (head_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_channel  (out_channel),
		.out_filtered (out_filtered),
		.out_rejected (out_rejected)
	);

	// Pack the result fields, padding with zeros.
	assign m_tdata = DATA_W'({out_filtered, out_channel});
	assign m_tuser = out_rejected;

endmodule

// File: rtl/gsr_checker.sv
// Port-level checks for the gyro spike rejector, attached by bind.
// Depends on gsr_pkg and the top level gyro_spike_rejector.
`timescale 1ns / 1ps

module gsr_checker #(
	parameter int CHANNELS     = 9,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [((gsr_pkg::CHANNEL_W+SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic [0:0]                          m_tuser
);

	localparam int FIELD_W = gsr_pkg::CHANNEL_W + SAMPLE_WIDTH;

	// A stalled result stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// Only a channel with state can ever have its sample replaced.
	a_reject_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (32'(m_tdata[gsr_pkg::CHANNEL_W-1:0]) < CHANNELS))
		else $error("rejection reported on a channel without state");

	// Padding above the packed fields is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata >> FIELD_W) == '0))
		else $error("nonzero padding in m_tdata");

endmodule

bind gyro_spike_rejector gsr_checker #(
	.CHANNELS     (CHANNELS),
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: test/tb.sv
// Self-checking testbench for gyro_spike_rejector.
// Drives the sample stream and the configuration channel, predicts every result
// with its own per-channel spike model, and depends on gsr_pkg and the block only.
`timescale 1ns / 1ps

module tb;

	localparam int CHANNELS     = 9;
	localparam int SAMPLE_WIDTH = 16;
	localparam int DATA_W       = ((gsr_pkg::CHANNEL_W + SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int PAD_LSB      = gsr_pkg::CHANNEL_W + SAMPLE_WIDTH;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	// An index that maps to no register; writes to it must change nothing.
	localparam logic [gsr_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd9;

	// One predicted result transfer.
	typedef struct {
		logic [gsr_pkg::CHANNEL_W-1:0] ch;
		logic [SAMPLE_WIDTH-1:0]       value;
		logic                          rej;
	} spike_result_t;

	// Scoreboard: keeps its own copy of the filter state and the expected results.
	class spike_scoreboard;
		logic [gsr_pkg::THRESH_W-1:0]   threshold;
		logic [gsr_pkg::LIMIT_W-1:0]    limit;
		logic signed [SAMPLE_WIDTH-1:0] held [CHANNELS];
		logic [gsr_pkg::COUNT_W-1:0]    streak [CHANNELS];
		spike_result_t                  pending_q [$];
		int                             errors;

		function new();
			threshold = gsr_pkg::THRESH_RESET;
			limit = gsr_pkg::LIMIT_RESET;
			foreach (held[i]) begin
				held[i] = '0;
				streak[i] = '0;
			end
			errors = 0;
		endfunction

		function void set_register(input logic [gsr_pkg::CFG_INDEX_W-1:0] idx,
				input logic [gsr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				gsr_pkg::REG_SPIKE_THRESHOLD: threshold = data[gsr_pkg::THRESH_W-1:0];
				gsr_pkg::REG_PERSIST_LIMIT: limit = data[gsr_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the result of one accepted sample and update the channel state.
		function void note_sample(input logic [gsr_pkg::CHANNEL_W-1:0] ch,
				input logic signed [SAMPLE_WIDTH-1:0] smp);
			spike_result_t               r;
			int                          step;
			logic [gsr_pkg::COUNT_W-1:0] next_streak;
			r.ch = ch;
			r.value = smp;
			r.rej = 1'b0;
			if (ch < CHANNELS) begin
				step = int'(smp) - int'(held[ch]);
				if (step < 0)
					step = -step;
				if (step > int'(threshold)) begin
					next_streak = streak[ch] + gsr_pkg::COUNT_W'(1);
					if (next_streak < limit) begin
						streak[ch] = next_streak;
						r.value = held[ch];
						r.rej = 1'b1;
					end else begin
						held[ch] = smp;
						streak[ch] = '0;
					end
				end else begin
					held[ch] = smp;
					streak[ch] = '0;
				end
			end
			pending_q.push_back(r);
		endfunction

		function void complain(input string what, input int unsigned want,
				input int unsigned got);
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
		endfunction

		// Compare one result transfer with the oldest expectation.
		function void check_result(input logic [DATA_W-1:0] data, input logic rej);
			spike_result_t want;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result transfer, data %0h", $time, data);
				return;
			end
			want = pending_q.pop_front();
			if (data[gsr_pkg::CHANNEL_W-1:0] !== want.ch)
				complain("channel_out", want.ch, data[gsr_pkg::CHANNEL_W-1:0]);
			if (data[PAD_LSB-1:gsr_pkg::CHANNEL_W] !== want.value)
				complain("filtered", want.value, data[PAD_LSB-1:gsr_pkg::CHANNEL_W]);
			if (rej !== want.rej)
				complain("rejected", want.rej, rej);
			if (data[DATA_W-1:PAD_LSB] !== '0)
				complain("data pad", 0, data[DATA_W-1:PAD_LSB]);
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [gsr_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [gsr_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [DATA_W-1:0]               s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [DATA_W-1:0]               m_tdata;
	logic [0:0]                      m_tuser;

	spike_scoreboard sb;
	bit              gaps_on;
	bit              hold_req;
	bit              hold_done;
	int              quiet_cycles;

	gyro_spike_rejector #(
		.CHANNELS(CHANNELS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 50 MHz clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin
		m_tready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready = !(gaps_on && $urandom_range(99) < 11);
			end
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0]);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("gyro_spike_rejector test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample, with an occasional gap in front, and wait for its transfer.
	task automatic send_sample(input logic [gsr_pkg::CHANNEL_W-1:0] ch,
			input logic [SAMPLE_WIDTH-1:0] smp);
		@(negedge clk);
		if (gaps_on && $urandom_range(99) < 11) begin
			s_tvalid = 1'b0;
			s_tdata = DATA_W'({$urandom} & ((1 << PAD_LSB) - 1));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(DATA_W - PAD_LSB){1'b0}}, smp, ch};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(ch, smp);
	endtask

	// Stop offering samples and wait until every expected result has come.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [gsr_pkg::CFG_INDEX_W-1:0] idx,
			input logic [gsr_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic [gsr_pkg::THRESH_W-1:0] thr,
			input logic [gsr_pkg::LIMIT_W-1:0] lim);
		wait_drained();
		write_reg(gsr_pkg::REG_SPIKE_THRESHOLD, thr);
		write_reg(gsr_pkg::REG_PERSIST_LIMIT,
			{{(gsr_pkg::CFG_DATA_W - gsr_pkg::LIMIT_W){1'b0}}, lim});
	endtask

	// Choose a sample relative to the held value: near the threshold, right at it,
	// a clear spike, or anything at all.
	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(
			input logic [gsr_pkg::CHANNEL_W-1:0] ch, input bit spike);
		int                      base;
		int                      thr;
		int                      pick;
		int                      offs;
		logic [SAMPLE_WIDTH-1:0] r;
		base = (ch < CHANNELS) ? int'(sb.held[ch]) : 0;
		thr = int'(sb.threshold);
		pick = spike ? 60 : int'($urandom_range(99));
		if (pick < 40)
			offs = int'($urandom_range(2 * thr + 2)) - thr - 1;
		else if (pick < 55)
			offs = thr + int'($urandom_range(1));
		else if (pick < 85)
			offs = thr + 1 + int'($urandom_range(3000));
		else
			return SAMPLE_WIDTH'($urandom);
		if ($urandom_range(1))
			offs = -offs;
		r = SAMPLE_WIDTH'(base + offs);
		return r;
	endfunction

	// Random traffic: mostly per-channel streams with spike bursts of random
	// length, some samples on unused channel numbers.
	task automatic run_random(input int n);
		int                            sent;
		int                            burst;
		logic [gsr_pkg::CHANNEL_W-1:0] ch;
		logic [SAMPLE_WIDTH-1:0]       lvl;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 20) begin
				ch = gsr_pkg::CHANNEL_W'($urandom_range(CHANNELS - 1));
				lvl = pick_sample(ch, 1'b1);
				burst = $urandom_range(1, 16);
				repeat (burst) begin
					send_sample(ch, SAMPLE_WIDTH'(lvl + $urandom_range(3)));
					sent++;
				end
			end else begin
				if ($urandom_range(99) < 88)
					ch = gsr_pkg::CHANNEL_W'($urandom_range(CHANNELS - 1));
				else
					ch = gsr_pkg::CHANNEL_W'($urandom_range(15, CHANNELS));
				send_sample(ch, pick_sample(ch, 1'b0));
				sent++;
			end
		end
	endtask

	// Main sequence.
	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: step boundary, full-scale spikes, unused channels.
		send_sample(4'd0, 16'h0000);
		send_sample(4'd0, 16'd49);
		send_sample(4'd0, 16'd99);
		send_sample(4'd0, 16'h0000);
		send_sample(4'd8, 16'h7FFF);
		send_sample(4'd8, 16'h8000);
		send_sample(4'd9, 16'h8000);
		send_sample(4'd15, 16'h7FFF);
		send_sample(4'd12, 16'h5A5A);
		// A persistent new level is taken on the sixth large step.
		repeat (6) send_sample(4'd1, 16'h0400);

		// A persistence limit of zero takes the first large step at once.
		apply_settings(16'd0, 4'd0);
		send_sample(4'd2, 16'h0001);
		send_sample(4'd2, 16'hFFFF);

		// Largest threshold: a full-range step still passes.
		apply_settings(16'hFFFF, 4'd15);
		send_sample(4'd3, 16'h8000);
		send_sample(4'd3, 16'h7FFF);

		// Build up a count, then lower the limit beneath it.
		apply_settings(16'd0, 4'd15);
		repeat (4) send_sample(4'd4, 16'h0010);
		wait_drained();
		write_reg(gsr_pkg::REG_PERSIST_LIMIT, 16'd2);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		send_sample(4'd4, 16'h0020);

		// Random phases over several settings.
		apply_settings(16'd49, 4'd6);
		hold_req = 1'b1;
		run_random(350);

		apply_settings(16'd0, 4'd1);
		gaps_on = 1'b0;
		run_random(250);
		gaps_on = 1'b1;

		apply_settings(16'hFFFF, 4'd15);
		run_random(200);

		apply_settings(16'd300, 4'd3);
		run_random(150);
		wait_drained();
		run_random(150);

		apply_settings(gsr_pkg::THRESH_W'($urandom_range(2000)),
			gsr_pkg::LIMIT_W'($urandom_range(1, 15)));
		run_random(300);

		apply_settings(16'd100, 4'd0);
		run_random(150);

		apply_settings(16'd49, 4'd15);
		run_random(125);
		wait_drained();
		write_reg(gsr_pkg::REG_PERSIST_LIMIT, 16'd2);
		run_random(125);

		wait_drained();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("gyro_spike_rejector test passed");
		else
			$display("gyro_spike_rejector test failed");
		$finish;
	end

endmodule
